/* hdl/btpe_pkg.sv */
// Shared types and constants of the binary trie predecessor engine.
package btpe_pkg;

  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned TAG_BITS   = 16;
  localparam int unsigned POOL_NODES = 1024;
  localparam int unsigned IDX_BITS   = $clog2(POOL_NODES);
  localparam int unsigned PT_BITS    = IDX_BITS + 1;
  localparam int unsigned LVL_BITS   = $clog2(KEY_BITS);

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_FIND   = 3'd1;
  localparam logic [2:0] CMD_FLOOR  = 3'd2;
  localparam logic [2:0] CMD_PRED   = 3'd3;
  localparam logic [2:0] CMD_SUCC   = 3'd4;

  localparam logic [1:0] FLAG_LEFT  = 2'b01;
  localparam logic [1:0] FLAG_RIGHT = 2'b10;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]          command;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] payload;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [KEY_BITS-1:0] result_key;
    logic [TAG_BITS-1:0] result_payload;
    logic [1:0]          status;
  } out_t;

  // One node of the pool: trie links for internal nodes, list links for leaves
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [IDX_BITS-1:0] left;
    logic [IDX_BITS-1:0] right;
    logic [1:0]          flags;
    logic [IDX_BITS-1:0] prev;
    logic [IDX_BITS-1:0] next;
    logic [TAG_BITS-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_t;

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001,
    S_WRD    = 23'h000002,
    S_WCHK   = 23'h000004,
    S_DISP   = 23'h000008,
    S_IRD    = 23'h000010,
    S_IMOD   = 23'h000020,
    S_ITRD   = 23'h000040,
    S_ITCHK  = 23'h000080,
    S_IWR    = 23'h000100,
    S_LST    = 23'h000200,
    S_LNB    = 23'h000400,
    S_LLEAF  = 23'h000800,
    S_LPRD   = 23'h001000,
    S_LPWR   = 23'h002000,
    S_LNRD   = 23'h004000,
    S_LNWR   = 23'h008000,
    S_QRD    = 23'h010000,
    S_QCHK   = 23'h020000,
    S_QRD2   = 23'h040000,
    S_QCHK2  = 23'h080000,
    S_ERD    = 23'h100000,
    S_ELD    = 23'h200000,
    S_OUT    = 23'h400000
  } state_e;

endpackage

/* hdl/btpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module btpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/btpe_cmp.sv */
// Shared key comparator used by every ordering decision of the sequencer.
module btpe_cmp (
  input  logic [btpe_pkg::KEY_BITS-1:0] a_i,
  input  logic [btpe_pkg::KEY_BITS-1:0] b_i,
  output btpe_pkg::cmp_t                res_o
);

  // order a against b
  always_comb begin
    res_o.lt = a_i < b_i;
    res_o.eq = a_i == b_i;
    res_o.gt = a_i > b_i;
  end

endmodule

/* hdl/binary_trie_predecessor_engine_unit.sv */
// Top level: command sequencer over the node pool RAM and the shared comparator.
//
// Ordered map from 16-bit keys to 16-bit payloads kept as a binary trie in a
// 1024-node pool, node 0 being the root. One command is in work at a time:
// in_ready_o is high only while the sequencer is idle, and a finished result
// waits in the output register without blocking the next command. Every trie
// level costs a pool RAM read, then a decision; a query walks at most 16 levels.
// An insert walks once to find the miss level, then walks again rewriting each
// node on the path, then splices the leaf into the sorted list.
module binary_trie_predecessor_engine_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  btpe_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output btpe_pkg::out_t   out_data_o
);

  localparam logic [btpe_pkg::IDX_BITS-1:0] NULL_IDX = '0;

  btpe_pkg::state_e state_q, state_d;

  logic [2:0]                    cmd_q, cmd_d;
  logic [btpe_pkg::KEY_BITS-1:0] key_q, key_d;
  logic [btpe_pkg::TAG_BITS-1:0] tag_q, tag_d;
  logic [btpe_pkg::IDX_BITS-1:0] cur_q, cur_d;
  logic [btpe_pkg::LVL_BITS-1:0] lvl_q, lvl_d;
  logic [btpe_pkg::LVL_BITS-1:0] miss_q, miss_d;
  logic                          exact_q, exact_d;
  logic [btpe_pkg::IDX_BITS-1:0] r_q, r_d;
  logic [btpe_pkg::IDX_BITS-1:0] eidx_q, eidx_d;
  logic [btpe_pkg::IDX_BITS-1:0] nb_q, nb_d;
  logic [btpe_pkg::IDX_BITS-1:0] leaf_q, leaf_d;
  logic [btpe_pkg::IDX_BITS-1:0] alloc_q, alloc_d;
  logic [btpe_pkg::IDX_BITS-1:0] prev_q, prev_d;
  logic [btpe_pkg::IDX_BITS-1:0] next_q, next_d;
  logic                          fresh_q, fresh_d;
  logic                          setother_q, setother_d;
  logic [btpe_pkg::PT_BITS-1:0]  pool_top_q, pool_top_d;
  logic [btpe_pkg::IDX_BITS-1:0] root_left_q, root_left_d;
  logic [btpe_pkg::IDX_BITS-1:0] root_right_q, root_right_d;
  logic [1:0]                    root_flags_q, root_flags_d;
  logic [1:0]                    status_q, status_d;
  btpe_pkg::rec_t                rec_q, rec_d;
  btpe_pkg::out_t                res_q, res_d;
  btpe_pkg::out_t                out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic                          ram_we, ram_re;
  logic [btpe_pkg::IDX_BITS-1:0] ram_waddr, ram_raddr;
  btpe_pkg::rec_t                ram_wdata, ram_rdata;
  btpe_pkg::cmp_t                cmp;

  btpe_pkg::rec_t                root_rec, cur_rec, mod_rec;
  logic                          dir;
  logic                          absent;
  logic [btpe_pkg::IDX_BITS-1:0] new_link;
  logic [btpe_pkg::PT_BITS+1:0]  need;

  btpe_ram #(
    .Width ($bits(btpe_pkg::rec_t)),
    .Depth (btpe_pkg::POOL_NODES)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  btpe_cmp u_cmp (
    .a_i   (ram_rdata.key),
    .b_i   (key_q),
    .res_o (cmp)
  );

  // root record lives in flops so it reads as empty right after reset
  always_comb begin
    root_rec       = '0;
    root_rec.left  = root_left_q;
    root_rec.right = root_right_q;
    root_rec.flags = root_flags_q;
  end

  assign cur_rec  = (cur_q == NULL_IDX) ? root_rec : ram_rdata;
  assign dir      = key_q[lvl_q];
  assign absent   = dir ? !rec_q.flags[1] : !rec_q.flags[0];
  assign new_link = (lvl_q != '0) ? alloc_q : leaf_q;
  assign need     = (btpe_pkg::PT_BITS+2)'(pool_top_q) + (btpe_pkg::PT_BITS+2)'(miss_q)
                    + (btpe_pkg::PT_BITS+2)'(1);

  // rewrite the current path node during insert
  always_comb begin
    mod_rec = rec_q;
    if (dir) begin
      if (setother_q) begin
        mod_rec.left = leaf_q;
      end
      if (absent) begin
        mod_rec.right = new_link;
        mod_rec.flags = rec_q.flags | btpe_pkg::FLAG_RIGHT;
      end
    end else begin
      if (setother_q) begin
        mod_rec.right = leaf_q;
      end
      if (absent) begin
        mod_rec.left  = new_link;
        mod_rec.flags = rec_q.flags | btpe_pkg::FLAG_LEFT;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    tag_d        = tag_q;
    cur_d        = cur_q;
    lvl_d        = lvl_q;
    miss_d       = miss_q;
    exact_d      = exact_q;
    r_d          = r_q;
    eidx_d       = eidx_q;
    nb_d         = nb_q;
    leaf_d       = leaf_q;
    alloc_d      = alloc_q;
    prev_d       = prev_q;
    next_d       = next_q;
    fresh_d      = fresh_q;
    setother_d   = setother_q;
    pool_top_d   = pool_top_q;
    root_left_d  = root_left_q;
    root_right_d = root_right_q;
    root_flags_d = root_flags_q;
    status_d     = status_q;
    rec_d        = rec_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = mod_rec;
    ram_re       = 1'b0;
    ram_raddr    = cur_q;

    unique case (state_q)
      btpe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.command;
          key_d   = in_data_i.key;
          tag_d   = in_data_i.payload;
          cur_d   = NULL_IDX;
          lvl_d   = btpe_pkg::LVL_BITS'(btpe_pkg::KEY_BITS - 1);
          state_d = btpe_pkg::S_WRD;
        end
      end

      // search walk: fetch node, then follow or stop at the first absent child
      btpe_pkg::S_WRD: begin
        ram_re  = cur_q != NULL_IDX;
        state_d = btpe_pkg::S_WCHK;
      end

      btpe_pkg::S_WCHK: begin
        if (!(dir ? cur_rec.flags[1] : cur_rec.flags[0])) begin
          exact_d = 1'b0;
          miss_d  = lvl_q;
          r_d     = dir ? cur_rec.right : cur_rec.left;
          state_d = btpe_pkg::S_DISP;
        end else begin
          cur_d = dir ? cur_rec.right : cur_rec.left;
          if (lvl_q == '0) begin
            exact_d = 1'b1;
            r_d     = dir ? cur_rec.right : cur_rec.left;
            state_d = btpe_pkg::S_DISP;
          end else begin
            lvl_d   = lvl_q - 1'b1;
            state_d = btpe_pkg::S_WRD;
          end
        end
      end

      btpe_pkg::S_DISP: begin
        status_d = btpe_pkg::ST_OK;
        eidx_d   = NULL_IDX;
        state_d  = btpe_pkg::S_ERD;
        if (cmd_q == btpe_pkg::CMD_INSERT) begin
          if (exact_q) begin
            eidx_d   = r_q;
            status_d = btpe_pkg::ST_DUP;
          end else if (need > (btpe_pkg::PT_BITS+2)'(btpe_pkg::POOL_NODES)) begin
            status_d = btpe_pkg::ST_FULL;
          end else begin
            leaf_d     = pool_top_q[btpe_pkg::IDX_BITS-1:0];
            alloc_d    = pool_top_q[btpe_pkg::IDX_BITS-1:0] + 1'b1;
            pool_top_d = need[btpe_pkg::PT_BITS-1:0];
            cur_d      = NULL_IDX;
            lvl_d      = btpe_pkg::LVL_BITS'(btpe_pkg::KEY_BITS - 1);
            nb_d       = NULL_IDX;
            fresh_d    = 1'b0;
            state_d    = btpe_pkg::S_IRD;
          end
        end else if (cmd_q <= btpe_pkg::CMD_SUCC && r_q != NULL_IDX) begin
          state_d = btpe_pkg::S_QRD;
        end
      end

      // insert pass: rewrite each node on the key's path
      btpe_pkg::S_IRD: begin
        ram_re  = !fresh_q && cur_q != NULL_IDX;
        state_d = btpe_pkg::S_IMOD;
      end

      btpe_pkg::S_IMOD: begin
        rec_d = fresh_q ? '0 : cur_rec;
        if (dir ? !rec_d.flags[1] : !rec_d.flags[0]) begin
          if (nb_q == NULL_IDX) begin
            nb_d = dir ? rec_d.right : rec_d.left;
          end
        end
        priority if ((dir ? rec_d.left : rec_d.right) == NULL_IDX) begin
          setother_d = 1'b1;
          state_d    = btpe_pkg::S_IWR;
        end else if (dir ? !rec_d.flags[0] : !rec_d.flags[1]) begin
          state_d = btpe_pkg::S_ITRD;
        end else begin
          setother_d = 1'b0;
          state_d    = btpe_pkg::S_IWR;
        end
      end

      btpe_pkg::S_ITRD: begin
        ram_re    = 1'b1;
        ram_raddr = dir ? rec_q.left : rec_q.right;
        state_d   = btpe_pkg::S_ITCHK;
      end

      btpe_pkg::S_ITCHK: begin
        setother_d = dir ? cmp.gt : cmp.lt;
        state_d    = btpe_pkg::S_IWR;
      end

      btpe_pkg::S_IWR: begin
        if (cur_q == NULL_IDX) begin
          root_left_d  = mod_rec.left;
          root_right_d = mod_rec.right;
          root_flags_d = mod_rec.flags;
        end else begin
          ram_we = 1'b1;
        end
        if (absent) begin
          cur_d   = new_link;
          fresh_d = lvl_q != '0;
          if (lvl_q != '0) begin
            alloc_d = alloc_q + 1'b1;
          end
        end else begin
          cur_d   = dir ? rec_q.right : rec_q.left;
          fresh_d = 1'b0;
        end
        if (lvl_q == '0) begin
          state_d = btpe_pkg::S_LST;
        end else begin
          lvl_d   = lvl_q - 1'b1;
          state_d = btpe_pkg::S_IRD;
        end
      end

      // list splice: place the new leaf next to its neighbor leaf
      btpe_pkg::S_LST: begin
        if (nb_q == NULL_IDX) begin
          prev_d  = NULL_IDX;
          next_d  = NULL_IDX;
          state_d = btpe_pkg::S_LLEAF;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = nb_q;
          state_d   = btpe_pkg::S_LNB;
        end
      end

      btpe_pkg::S_LNB: begin
        if (cmp.gt) begin
          next_d = nb_q;
          prev_d = ram_rdata.prev;
        end else begin
          prev_d = nb_q;
          next_d = ram_rdata.next;
        end
        state_d = btpe_pkg::S_LLEAF;
      end

      btpe_pkg::S_LLEAF: begin
        ram_we         = 1'b1;
        ram_waddr      = leaf_q;
        ram_wdata      = '0;
        ram_wdata.key  = key_q;
        ram_wdata.tag  = tag_q;
        ram_wdata.prev = prev_q;
        ram_wdata.next = next_q;
        state_d        = btpe_pkg::S_LPRD;
      end

      btpe_pkg::S_LPRD: begin
        if (prev_q != NULL_IDX) begin
          ram_re    = 1'b1;
          ram_raddr = prev_q;
          state_d   = btpe_pkg::S_LPWR;
        end else begin
          state_d = btpe_pkg::S_LNRD;
        end
      end

      btpe_pkg::S_LPWR: begin
        ram_we         = 1'b1;
        ram_waddr      = prev_q;
        ram_wdata      = ram_rdata;
        ram_wdata.next = leaf_q;
        state_d        = btpe_pkg::S_LNRD;
      end

      btpe_pkg::S_LNRD: begin
        res_d.found          = 1'b1;
        res_d.result_key     = key_q;
        res_d.result_payload = tag_q;
        res_d.status         = btpe_pkg::ST_OK;
        if (next_q != NULL_IDX) begin
          ram_re    = 1'b1;
          ram_raddr = next_q;
          state_d   = btpe_pkg::S_LNWR;
        end else begin
          state_d = btpe_pkg::S_OUT;
        end
      end

      btpe_pkg::S_LNWR: begin
        ram_we         = 1'b1;
        ram_waddr      = next_q;
        ram_wdata      = ram_rdata;
        ram_wdata.prev = leaf_q;
        state_d        = btpe_pkg::S_OUT;
      end

      // queries: inspect the leaf met by the walk and step along the list
      btpe_pkg::S_QRD: begin
        ram_re    = 1'b1;
        ram_raddr = r_q;
        state_d   = btpe_pkg::S_QCHK;
      end

      btpe_pkg::S_QCHK: begin
        state_d = btpe_pkg::S_ERD;
        eidx_d  = NULL_IDX;
        unique case (cmd_q)
          btpe_pkg::CMD_FIND: begin
            eidx_d = exact_q ? r_q : NULL_IDX;
          end
          btpe_pkg::CMD_FLOOR: begin
            eidx_d = (cmp.lt || cmp.eq) ? r_q : ram_rdata.prev;
          end
          btpe_pkg::CMD_PRED: begin
            if (cmp.lt) begin
              eidx_d = r_q;
            end else if (cmp.eq || ram_rdata.prev == NULL_IDX) begin
              eidx_d = ram_rdata.prev;
            end else begin
              r_d     = ram_rdata.prev;
              state_d = btpe_pkg::S_QRD2;
            end
          end
          btpe_pkg::CMD_SUCC: begin
            if (cmp.gt) begin
              eidx_d = r_q;
            end else if (cmp.eq || ram_rdata.next == NULL_IDX) begin
              eidx_d = ram_rdata.next;
            end else begin
              r_d     = ram_rdata.next;
              state_d = btpe_pkg::S_QRD2;
            end
          end
          default: begin
            eidx_d = NULL_IDX;
          end
        endcase
      end

      btpe_pkg::S_QRD2: begin
        ram_re    = 1'b1;
        ram_raddr = r_q;
        state_d   = btpe_pkg::S_QCHK2;
      end

      btpe_pkg::S_QCHK2: begin
        if (cmd_q == btpe_pkg::CMD_PRED) begin
          eidx_d = cmp.lt ? r_q : ram_rdata.prev;
        end else begin
          eidx_d = cmp.gt ? r_q : ram_rdata.next;
        end
        state_d = btpe_pkg::S_ERD;
      end

      // fetch the answering leaf, if any, into the result
      btpe_pkg::S_ERD: begin
        ram_re    = eidx_q != NULL_IDX;
        ram_raddr = eidx_q;
        state_d   = btpe_pkg::S_ELD;
      end

      btpe_pkg::S_ELD: begin
        res_d.found          = eidx_q != NULL_IDX;
        res_d.result_key     = (eidx_q != NULL_IDX) ? ram_rdata.key : '0;
        res_d.result_payload = (eidx_q != NULL_IDX) ? ram_rdata.tag : '0;
        res_d.status         = status_q;
        state_d              = btpe_pkg::S_OUT;
      end

      // hold until the output register is free, then transfer the result
      btpe_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = btpe_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = btpe_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= btpe_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      pool_top_q   <= btpe_pkg::PT_BITS'(1);
      root_left_q  <= '0;
      root_right_q <= '0;
      root_flags_q <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pool_top_q   <= pool_top_d;
      root_left_q  <= root_left_d;
      root_right_q <= root_right_d;
      root_flags_q <= root_flags_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    tag_q      <= tag_d;
    cur_q      <= cur_d;
    lvl_q      <= lvl_d;
    miss_q     <= miss_d;
    exact_q    <= exact_d;
    r_q        <= r_d;
    eidx_q     <= eidx_d;
    nb_q       <= nb_d;
    leaf_q     <= leaf_d;
    alloc_q    <= alloc_d;
    prev_q     <= prev_d;
    next_q     <= next_d;
    fresh_q    <= fresh_d;
    setother_q <= setother_d;
    status_q   <= status_d;
    rec_q      <= rec_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = state_q == btpe_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // pool allocation never passes its size
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_top_q <= btpe_pkg::PT_BITS'(btpe_pkg::POOL_NODES))
    else $error("pool top beyond pool size");

  // root record is kept in flops, never in the pool RAM
  a_no_root_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ram_waddr != NULL_IDX)
    else $error("pool write to root slot");

  // a miss carries zero key and payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |->
      (out_data_o.result_key == '0 && out_data_o.result_payload == '0))
    else $error("miss with nonzero data");

  // a full pool rejection never reports a leaf
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == btpe_pkg::ST_FULL) |-> !out_data_o.found)
    else $error("pool full with found set");

  // a rejected insert leaves the pool fill untouched
  a_reject_keeps_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == btpe_pkg::S_DISP && status_d != btpe_pkg::ST_OK) |=> $stable(pool_top_q))
    else $error("pool changed on rejected insert");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the binary trie predecessor engine.
module testbench;

  localparam int unsigned N_RANDOM  = 1700;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam int unsigned DRAIN_CYC = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  btpe_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  btpe_pkg::out_t out_data;

  btpe_pkg::in_t  pending_q[$];
  btpe_pkg::out_t expected_q[$];
  int   mismatches = 0;
  int   sent_cnt = 0;
  int   recv_cnt = 0;
  int   quiet_cycles = 0;

  // Shadow copy of the node pool
  logic [btpe_pkg::KEY_BITS-1:0] sh_key   [btpe_pkg::POOL_NODES];
  logic [btpe_pkg::IDX_BITS-1:0] sh_left  [btpe_pkg::POOL_NODES];
  logic [btpe_pkg::IDX_BITS-1:0] sh_right [btpe_pkg::POOL_NODES];
  logic [1:0]                    sh_flags [btpe_pkg::POOL_NODES];
  logic [btpe_pkg::IDX_BITS-1:0] sh_prev  [btpe_pkg::POOL_NODES];
  logic [btpe_pkg::IDX_BITS-1:0] sh_next  [btpe_pkg::POOL_NODES];
  logic [btpe_pkg::TAG_BITS-1:0] sh_tag   [btpe_pkg::POOL_NODES];
  int unsigned                   sh_top;
  logic [btpe_pkg::IDX_BITS-1:0] sh_head;

  binary_trie_predecessor_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic btpe_pkg::out_t leaf_answer(logic [btpe_pkg::IDX_BITS-1:0] leaf,
                                                 btpe_pkg::status_e st);
    btpe_pkg::out_t r;
    r = '0;
    if (leaf != '0) begin
      r.found          = 1'b1;
      r.result_key     = sh_key[leaf];
      r.result_payload = sh_tag[leaf];
    end
    r.status = st;
    return r;
  endfunction

  function automatic logic [btpe_pkg::IDX_BITS-1:0] alloc_node(
      logic [btpe_pkg::KEY_BITS-1:0] k);
    logic [btpe_pkg::IDX_BITS-1:0] n;
    n = btpe_pkg::IDX_BITS'(sh_top);
    sh_top++;
    sh_key[n] = k;
    sh_left[n] = '0;
    sh_right[n] = '0;
    sh_flags[n] = '0;
    sh_prev[n] = '0;
    sh_next[n] = '0;
    sh_tag[n] = '0;
    return n;
  endfunction

  // Follow the key's path; return the leaf on a full match, else the thread
  function automatic logic [btpe_pkg::IDX_BITS-1:0] trace_path(
      logic [btpe_pkg::KEY_BITS-1:0] k, output bit exact, output int miss);
    logic [btpe_pkg::IDX_BITS-1:0] cur;
    cur = '0;
    for (int lv = btpe_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
      if (k[lv]) begin
        if ((sh_flags[cur] & btpe_pkg::FLAG_RIGHT) == 0) begin
          exact = 1'b0;
          miss = lv;
          return sh_right[cur];
        end
        cur = sh_right[cur];
      end else begin
        if ((sh_flags[cur] & btpe_pkg::FLAG_LEFT) == 0) begin
          exact = 1'b0;
          miss = lv;
          return sh_left[cur];
        end
        cur = sh_left[cur];
      end
    end
    exact = 1'b1;
    miss = -1;
    return cur;
  endfunction

  function automatic btpe_pkg::out_t insert_key(logic [btpe_pkg::KEY_BITS-1:0] k,
                                                logic [btpe_pkg::TAG_BITS-1:0] tg);
    bit exact;
    int miss;
    logic [btpe_pkg::IDX_BITS-1:0] hit, leaf, cur, nb, pv, nx;
    hit = trace_path(k, exact, miss);
    cur = '0;
    nb = '0;
    if (exact) return leaf_answer(hit, btpe_pkg::ST_DUP);
    if (sh_top + miss + 1 > btpe_pkg::POOL_NODES) return leaf_answer('0, btpe_pkg::ST_FULL);
    leaf = alloc_node(k);
    sh_tag[leaf] = tg;
    for (int lv = btpe_pkg::KEY_BITS - 1; lv >= 0; lv--) begin
      if (k[lv]) begin
        if ((sh_flags[cur] & btpe_pkg::FLAG_RIGHT) == 0 && nb == '0) nb = sh_right[cur];
        if (sh_left[cur] == '0) sh_left[cur] = leaf;
        else if ((sh_flags[cur] & btpe_pkg::FLAG_LEFT) == 0 && sh_key[sh_left[cur]] > k)
          sh_left[cur] = leaf;
        if ((sh_flags[cur] & btpe_pkg::FLAG_RIGHT) == 0) begin
          sh_right[cur] = (lv > 0) ? alloc_node('0) : leaf;
          sh_flags[cur] |= btpe_pkg::FLAG_RIGHT;
        end
        cur = sh_right[cur];
      end else begin
        if ((sh_flags[cur] & btpe_pkg::FLAG_LEFT) == 0 && nb == '0) nb = sh_left[cur];
        if (sh_right[cur] == '0) sh_right[cur] = leaf;
        else if ((sh_flags[cur] & btpe_pkg::FLAG_RIGHT) == 0 && sh_key[sh_right[cur]] < k)
          sh_right[cur] = leaf;
        if ((sh_flags[cur] & btpe_pkg::FLAG_LEFT) == 0) begin
          sh_left[cur] = (lv > 0) ? alloc_node('0) : leaf;
          sh_flags[cur] |= btpe_pkg::FLAG_LEFT;
        end
        cur = sh_left[cur];
      end
    end
    if (nb == '0) begin
      sh_head = leaf;
      return leaf_answer(leaf, btpe_pkg::ST_OK);
    end
    if (sh_key[nb] > k) begin
      nx = nb;
      pv = sh_prev[nb];
    end else begin
      pv = nb;
      nx = sh_next[nb];
    end
    sh_prev[leaf] = pv;
    sh_next[leaf] = nx;
    if (pv != '0) sh_next[pv] = leaf;
    if (nx != '0) sh_prev[nx] = leaf;
    if (pv == '0) sh_head = leaf;
    return leaf_answer(leaf, btpe_pkg::ST_OK);
  endfunction

  // Apply one command to the shadow trie and return its answer
  function automatic btpe_pkg::out_t trie_answer(btpe_pkg::in_t it);
    bit exact;
    int miss;
    logic [btpe_pkg::IDX_BITS-1:0] r, p, n;
    logic [btpe_pkg::KEY_BITS-1:0] k;
    k = it.key;
    if (it.command == btpe_pkg::CMD_INSERT) return insert_key(k, it.payload);
    if (it.command > btpe_pkg::CMD_SUCC) return leaf_answer('0, btpe_pkg::ST_OK);
    r = trace_path(k, exact, miss);
    if (r == '0) return leaf_answer('0, btpe_pkg::ST_OK);
    case (it.command)
      btpe_pkg::CMD_FIND: return leaf_answer(exact ? r : '0, btpe_pkg::ST_OK);
      btpe_pkg::CMD_FLOOR:
        return leaf_answer(sh_key[r] <= k ? r : sh_prev[r], btpe_pkg::ST_OK);
      btpe_pkg::CMD_PRED: begin
        if (sh_key[r] < k) return leaf_answer(r, btpe_pkg::ST_OK);
        p = sh_prev[r];
        if (sh_key[r] == k || p == '0 || sh_key[p] < k)
          return leaf_answer(p, btpe_pkg::ST_OK);
        return leaf_answer(sh_prev[p], btpe_pkg::ST_OK);
      end
      default: begin
        if (sh_key[r] > k) return leaf_answer(r, btpe_pkg::ST_OK);
        n = sh_next[r];
        if (sh_key[r] == k || n == '0 || sh_key[n] > k)
          return leaf_answer(n, btpe_pkg::ST_OK);
        return leaf_answer(sh_next[n], btpe_pkg::ST_OK);
      end
    endcase
  endfunction

  function automatic bit idle_now(int idx);
    if (idx >= 700 && idx < 1000) return 0;
    return $urandom_range(99) < 18;
  endfunction

  // Driver: predict on each transfer, then present the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(trie_answer(in_data));
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && !idle_now(sent_cnt)) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    btpe_pkg::out_t exp_r;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recv_cnt++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %p, got %p", recv_cnt, exp_r, out_data);
          end
        end
      end
      out_ready <= !idle_now(recv_cnt);
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic btpe_pkg::in_t make_item(logic [2:0] c,
                                              logic [btpe_pkg::KEY_BITS-1:0] k,
                                              logic [btpe_pkg::TAG_BITS-1:0] t);
    btpe_pkg::in_t it;
    it.command = c;
    it.key = k;
    it.payload = t;
    return it;
  endfunction

  initial begin
    logic [btpe_pkg::KEY_BITS-1:0] bases[4];
    logic [btpe_pkg::KEY_BITS-1:0] keys[$];
    logic [btpe_pkg::KEY_BITS-1:0] k;
    logic [2:0] c;
    int sel;
    for (int i = 0; i < btpe_pkg::POOL_NODES; i++) begin
      sh_left[i] = '0; sh_right[i] = '0; sh_flags[i] = '0;
      sh_prev[i] = '0; sh_next[i] = '0;
    end
    sh_top = 1;
    sh_head = '0;

    // Directed: empty trie queries, extremes, duplicates, unused commands
    for (int q = btpe_pkg::CMD_FIND; q <= btpe_pkg::CMD_SUCC; q++)
      pending_q.push_back(make_item(3'(q), 16'h8000, 16'h1234));
    pending_q.push_back(make_item(btpe_pkg::CMD_INSERT, 16'h8000, 16'hFFFF));
    pending_q.push_back(make_item(btpe_pkg::CMD_INSERT, 16'h0000, 16'hFFFF));
    pending_q.push_back(make_item(btpe_pkg::CMD_INSERT, 16'hFFFF, 16'h0000));
    pending_q.push_back(make_item(btpe_pkg::CMD_INSERT, 16'h0000, 16'hAAAA));
    pending_q.push_back(make_item(btpe_pkg::CMD_INSERT, 16'h8001, 16'h5555));
    for (int q = btpe_pkg::CMD_FIND; q <= btpe_pkg::CMD_SUCC; q++) begin
      pending_q.push_back(make_item(3'(q), 16'h0000, 16'hFFFF));
      pending_q.push_back(make_item(3'(q), 16'hFFFF, 16'h0000));
      pending_q.push_back(make_item(3'(q), 16'h7FFF, 16'h0000));
    end
    for (int q = btpe_pkg::CMD_SUCC + 1; q <= 7; q++)
      pending_q.push_back(make_item(3'(q), 16'h8000, 16'hFFFF));

    // Random: clustered inserts keep the pool alive; queries aim near stored keys
    foreach (bases[i]) bases[i] = 16'($urandom);
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        c = btpe_pkg::CMD_INSERT;
        if ($urandom_range(9) < 8) k = {bases[$urandom_range(3)][15:6], 6'($urandom)};
        else k = 16'($urandom);
        keys.push_back(k);
      end else if (sel < 97) begin
        c = 3'($urandom_range(btpe_pkg::CMD_FIND, btpe_pkg::CMD_SUCC));
        if (keys.size() > 0 && $urandom_range(3) != 0)
          k = keys[$urandom_range(keys.size() - 1)] + 16'($signed($urandom_range(4)) - 2);
        else if ($urandom_range(1)) k = {bases[$urandom_range(3)][15:6], 6'($urandom)};
        else k = 16'($urandom);
      end else begin
        c = 3'($urandom_range(btpe_pkg::CMD_SUCC + 1, 7));
        k = 16'($urandom);
      end
      pending_q.push_back(make_item(c, k, 16'($urandom)));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
